// ===== rtl/dtab_pkg.sv =====
`timescale 1ns / 1ps

package dtab_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;
  localparam int unsigned DEPTH_BITS_DEF = 24;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [1:0] {
    CFG_DEPTH_TEST   = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_WRITTEN  = 2'd0,
    STATUS_CLIPPED  = 2'd1,
    STATUS_REJECTED = 2'd2,
    STATUS_READ     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_BLEND
  } state_e;

  typedef enum logic [1:0] {
    BL_IDLE,
    BL_MUL,
    BL_SUM,
    BL_DIV
  } blend_state_e;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } colour_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

  typedef struct packed {
    logic               op;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic signed [23:0] frag_depth;
    logic [7:0]         frag_red;
    logic [7:0]         frag_green;
    logic [7:0]         frag_blue;
    logic [7:0]         frag_alpha;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic [7:0]         out_alpha;
    logic signed [23:0] out_depth;
  } result_t;

endpackage

// ===== rtl/dtab_store.sv =====
`timescale 1ns / 1ps

module dtab_store #(
  parameter int unsigned MAX_WIDTH  = dtab_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = dtab_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned DEPTH_BITS = dtab_pkg::DEPTH_BITS_DEF,
  localparam int unsigned ENTRIES   = MAX_WIDTH * MAX_HEIGHT,
  localparam int unsigned ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dtab_pkg::mem_ctl_t       ctl_i,
  input  logic [ADDR_W-1:0]        addr_i,
  input  dtab_pkg::colour_t        colour_i,
  input  logic [DEPTH_BITS-1:0]    depth_i,
  output dtab_pkg::colour_t        colour_o,
  output logic [DEPTH_BITS-1:0]    depth_o,
  output logic                     ready_o
);

  localparam logic [DEPTH_BITS-1:0] DEPTH_CLEAR = {1'b0, {(DEPTH_BITS - 1){1'b1}}};
  localparam logic [ADDR_W-1:0]     LAST_ADDR   = ADDR_W'(ENTRIES - 1);

  dtab_pkg::colour_t     colour_mem [ENTRIES];
  logic [DEPTH_BITS-1:0] depth_mem  [ENTRIES];

  logic [ADDR_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic                  clr_busy_q, clr_busy_d;
  logic                  clr_last;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  dtab_pkg::colour_t     wr_colour;
  logic [DEPTH_BITS-1:0] wr_depth;
  logic                  rd_en;

  dtab_pkg::colour_t     colour_rd_q;
  logic [DEPTH_BITS-1:0] depth_rd_q;

  assign clr_last = (clr_cnt_q == LAST_ADDR);

  always_comb begin
    clr_busy_d = clr_busy_q & ~clr_last;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q && !clr_last) begin
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // clearing sweep owns the port until it finishes
  always_comb begin
    wr_en     = clr_busy_q | (ctl_i.en & ctl_i.we);
    wr_addr   = clr_busy_q ? clr_cnt_q : addr_i;
    wr_colour = clr_busy_q ? '0 : colour_i;
    wr_depth  = clr_busy_q ? DEPTH_CLEAR : depth_i;
    rd_en     = ~clr_busy_q & ctl_i.en & ~ctl_i.we;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      colour_mem[wr_addr] <= wr_colour;
      depth_mem[wr_addr]  <= wr_depth;
    end
    if (rd_en) begin
      colour_rd_q <= colour_mem[addr_i];
      depth_rd_q  <= depth_mem[addr_i];
    end
  end

  assign colour_o = colour_rd_q;
  assign depth_o  = depth_rd_q;
  assign ready_o  = ~clr_busy_q;

endmodule

// ===== rtl/dtab_blend.sv =====
`timescale 1ns / 1ps

module dtab_blend (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dtab_pkg::colour_t src_i,
  input  dtab_pkg::colour_t dst_i,
  output logic              done_o,
  output dtab_pkg::colour_t colour_o
);

  localparam int unsigned LANES = 3;

  dtab_pkg::blend_state_e state_q, state_d;

  dtab_pkg::colour_t src_q, dst_q;
  logic [7:0]        src_c [LANES];
  logic [7:0]        dst_c [LANES];

  logic [15:0] ac_q  [LANES];
  logic [15:0] ac_d  [LANES];
  logic [24:0] rem_q [LANES];
  logic [24:0] rem_d [LANES];
  logic [7:0]  quo_q [LANES];
  logic [7:0]  quo_d [LANES];
  logic [15:0] ea_q, ea_d;
  logic [15:0] s_q, s_d;
  logic [22:0] dv_q, dv_d;
  logic [7:0]  alpha_q, alpha_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [23:0] alpha_prod;

  logic load_en, mul_en, sum_en, div_en;

  function automatic logic [7:0] ALPHA_MINUS(input logic [7:0] a);
    return dtab_pkg::ALPHA_OPAQUE - a;
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtab_pkg::BL_IDLE: begin
        if (start_i) begin
          state_d = dtab_pkg::BL_MUL;
        end
      end
      dtab_pkg::BL_MUL: state_d = dtab_pkg::BL_SUM;
      dtab_pkg::BL_SUM: state_d = dtab_pkg::BL_DIV;
      dtab_pkg::BL_DIV: begin
        if (cnt_q == 3'd0) begin
          state_d = dtab_pkg::BL_IDLE;
        end
      end
      default: state_d = dtab_pkg::BL_IDLE;
    endcase
  end

  always_comb begin
    load_en = 1'b0;
    mul_en  = 1'b0;
    sum_en  = 1'b0;
    div_en  = 1'b0;
    unique case (state_q)
      dtab_pkg::BL_IDLE: load_en = start_i;
      dtab_pkg::BL_MUL:  mul_en  = 1'b1;
      dtab_pkg::BL_SUM:  sum_en  = 1'b1;
      dtab_pkg::BL_DIV:  div_en  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    src_c[0] = src_q.red;
    src_c[1] = src_q.green;
    src_c[2] = src_q.blue;
    dst_c[0] = dst_q.red;
    dst_c[1] = dst_q.green;
    dst_c[2] = dst_q.blue;
  end

  // products, weighted sums, then one quotient bit per cycle in each lane
  always_comb begin
    ea_d  = 16'(dst_q.alpha) * 16'(ALPHA_MINUS(src_q.alpha));
    s_d   = 16'({src_q.alpha, 8'd0}) - 16'(src_q.alpha) + ea_q;
    dv_d  = sum_en ? (23'(s_d) << 7) : (dv_q >> 1);
    cnt_d = sum_en ? 3'd7 : (cnt_q - 3'd1);
    for (int i = 0; i < LANES; i++) begin
      ac_d[i] = 16'(src_c[i]) * 16'(src_q.alpha);
      if (sum_en) begin
        rem_d[i] = 25'({ac_q[i], 8'd0}) - 25'(ac_q[i]) + 25'(ea_q) * 25'(dst_c[i]);
        quo_d[i] = '0;
      end else if (rem_q[i] >= 25'(dv_q)) begin
        rem_d[i] = rem_q[i] - 25'(dv_q);
        quo_d[i] = {quo_q[i][6:0], 1'b1};
      end else begin
        rem_d[i] = rem_q[i];
        quo_d[i] = {quo_q[i][6:0], 1'b0};
      end
    end
    alpha_prod = (24'(s_q) + 24'd1) * 24'd257;
    alpha_d    = alpha_prod[23:16];
    done_d     = div_en & (cnt_q == 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtab_pkg::BL_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      src_q <= src_i;
      dst_q <= dst_i;
    end
    if (mul_en) begin
      ac_q <= ac_d;
      ea_q <= ea_d;
    end
    if (sum_en) begin
      s_q <= s_d;
    end
    if (sum_en || div_en) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dv_q  <= dv_d;
      cnt_q <= cnt_d;
    end
    if (div_en) begin
      alpha_q <= alpha_d;
    end
  end

  // both alphas zero leaves the fragment colour unblended
  always_comb begin
    if (s_q == 16'd0) begin
      colour_o = src_q;
    end else begin
      colour_o.alpha = alpha_q;
      colour_o.blue  = quo_q[2];
      colour_o.green = quo_q[1];
      colour_o.red   = quo_q[0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/depth_test_alpha_blend_pixel_write.sv =====
`timescale 1ns / 1ps
// after reset the stores are swept, one entry a cycle, and busy stays high until the
// sweep has finished; configuration writes are taken throughout
// an item outside the frame gives its result in the cycle after start, one per cycle
// read, depth reject and opaque write: the store read, then the result, is registered; no new item while busy
// translucent write: the result waits for the blend unit and its shared 8-step divider
// results are strobed for one cycle; the receiver cannot stall

module depth_test_alpha_blend_pixel_write #(
  parameter int unsigned MAX_WIDTH  = dtab_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = dtab_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned DEPTH_BITS = dtab_pkg::DEPTH_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  dtab_pkg::item_t                     item_i,
  output logic                                res_valid_o,
  output dtab_pkg::result_t                   res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dtab_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dtab_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned ENTRIES = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [15:0]        MW16    = 16'(MAX_WIDTH);
  localparam logic [15:0]        MH16    = 16'(MAX_HEIGHT);
  localparam logic signed [32:0] DMAX    = (33'sd1 <<< (DEPTH_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] DMIN    = -DMAX - 33'sd1;
  localparam logic signed [32:0] OUT_MAX = 33'sd8388607;
  localparam logic signed [32:0] OUT_MIN = -33'sd8388608;

  dtab_pkg::state_e state_q, state_d;

  logic                      dte_q;
  logic [8:0]                frame_w_q, frame_h_q;

  logic                      op_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [DEPTH_BITS-1:0]     z_q;
  dtab_pkg::colour_t         frag_q;

  dtab_pkg::result_t         res_q, res_d;
  logic                      res_valid_q;
  logic                      res_load;

  logic                      accept;
  logic [15:0]               w_eff, h_eff;
  logic                      in_clip;
  logic [31:0]               addr_full;
  logic [ADDR_W-1:0]         in_addr;
  logic signed [32:0]        z_ext, z_sat;
  dtab_pkg::colour_t         in_frag;

  dtab_pkg::mem_ctl_t        mem_ctl;
  logic [ADDR_W-1:0]         mem_addr;
  dtab_pkg::colour_t         mem_colour;
  dtab_pkg::colour_t         st_colour;
  logic [DEPTH_BITS-1:0]     st_depth;
  logic                      store_ready;

  logic signed [32:0]        st_depth_ext, z_q_ext;
  logic                      reject;
  logic                      need_blend;

  logic                      blend_start;
  logic                      blend_done;
  dtab_pkg::colour_t         blend_colour;

  function automatic logic signed [23:0] depth_out(input logic signed [32:0] d);
    if (d > OUT_MAX) begin
      return OUT_MAX[23:0];
    end else if (d < OUT_MIN) begin
      return OUT_MIN[23:0];
    end
    return d[23:0];
  endfunction

  function automatic dtab_pkg::result_t make_result(input dtab_pkg::status_e st,
                                                    input dtab_pkg::colour_t c,
                                                    input logic signed [23:0] d);
    dtab_pkg::result_t r;
    r.status    = st;
    r.out_red   = c.red;
    r.out_green = c.green;
    r.out_blue  = c.blue;
    r.out_alpha = c.alpha;
    r.out_depth = d;
    return r;
  endfunction

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dte_q     <= 1'b0;
      frame_w_q <= 9'd256;
      frame_h_q <= 9'd256;
    end else if (cfg_valid_i) begin
      unique case (dtab_pkg::cfg_idx_e'(cfg_index_i))
        dtab_pkg::CFG_DEPTH_TEST:   dte_q     <= cfg_data_i[0];
        dtab_pkg::CFG_FRAME_WIDTH:  frame_w_q <= cfg_data_i;
        dtab_pkg::CFG_FRAME_HEIGHT: frame_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item decode
  assign accept = start & (state_q == dtab_pkg::ST_IDLE);
  assign busy   = (state_q != dtab_pkg::ST_IDLE);

  always_comb begin
    w_eff   = (16'(frame_w_q) < MW16) ? 16'(frame_w_q) : MW16;
    h_eff   = (16'(frame_h_q) < MH16) ? 16'(frame_h_q) : MH16;
    in_clip = item_i.pixel_x[15] | (16'(item_i.pixel_x) >= w_eff) |
              item_i.pixel_y[15] | (16'(item_i.pixel_y) >= h_eff);
    addr_full = 32'($unsigned(item_i.pixel_y)) * 32'(MAX_WIDTH) +
                32'($unsigned(item_i.pixel_x));
    in_addr   = addr_full[ADDR_W-1:0];
    z_ext     = 33'(item_i.frag_depth);
    if (z_ext > DMAX) begin
      z_sat = DMAX;
    end else if (z_ext < DMIN) begin
      z_sat = DMIN;
    end else begin
      z_sat = z_ext;
    end
    in_frag.red   = item_i.frag_red;
    in_frag.green = item_i.frag_green;
    in_frag.blue  = item_i.frag_blue;
    in_frag.alpha = item_i.frag_alpha;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= item_i.op;
      addr_q <= in_addr;
      z_q    <= z_sat[DEPTH_BITS-1:0];
      frag_q <= in_frag;
    end
  end

  // stored entry check
  always_comb begin
    st_depth_ext = 33'($signed(st_depth));
    z_q_ext      = 33'($signed(z_q));
    reject       = dte_q & (st_depth_ext <= z_q_ext);
    need_blend   = ~op_q & ~reject & (frag_q.alpha != dtab_pkg::ALPHA_OPAQUE);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtab_pkg::ST_CLEAR: begin
        if (store_ready) begin
          state_d = dtab_pkg::ST_IDLE;
        end
      end
      dtab_pkg::ST_IDLE: begin
        if (accept && !in_clip) begin
          state_d = dtab_pkg::ST_EVAL;
        end
      end
      dtab_pkg::ST_EVAL: begin
        state_d = need_blend ? dtab_pkg::ST_BLEND : dtab_pkg::ST_IDLE;
      end
      dtab_pkg::ST_BLEND: begin
        if (blend_done) begin
          state_d = dtab_pkg::ST_IDLE;
        end
      end
      default: state_d = dtab_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl     = '0;
    mem_addr    = addr_q;
    mem_colour  = frag_q;
    blend_start = 1'b0;
    res_load    = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      dtab_pkg::ST_CLEAR: ;
      dtab_pkg::ST_IDLE: begin
        mem_addr = in_addr;
        if (accept) begin
          if (in_clip) begin
            res_load     = 1'b1;
            res_d        = '0;
            res_d.status = dtab_pkg::STATUS_CLIPPED;
          end else begin
            mem_ctl.en = 1'b1;
          end
        end
      end
      dtab_pkg::ST_EVAL: begin
        if (op_q) begin
          res_load = 1'b1;
          res_d    = make_result(dtab_pkg::STATUS_READ, st_colour, depth_out(st_depth_ext));
        end else if (reject) begin
          res_load = 1'b1;
          res_d    = make_result(dtab_pkg::STATUS_REJECTED, st_colour,
                                 depth_out(st_depth_ext));
        end else if (need_blend) begin
          blend_start = 1'b1;
        end else begin
          mem_ctl.en = 1'b1;
          mem_ctl.we = 1'b1;
          res_load   = 1'b1;
          res_d      = make_result(dtab_pkg::STATUS_WRITTEN, frag_q, depth_out(z_q_ext));
        end
      end
      dtab_pkg::ST_BLEND: begin
        mem_colour = blend_colour;
        if (blend_done) begin
          mem_ctl.en = 1'b1;
          mem_ctl.we = 1'b1;
          res_load   = 1'b1;
          res_d      = make_result(dtab_pkg::STATUS_WRITTEN, blend_colour,
                                   depth_out(z_q_ext));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtab_pkg::ST_CLEAR;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  dtab_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mem_ctl),
    .addr_i   (mem_addr),
    .colour_i (mem_colour),
    .depth_i  (z_q),
    .colour_o (st_colour),
    .depth_o  (st_depth),
    .ready_o  (store_ready)
  );

  dtab_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (blend_start),
    .src_i    (frag_q),
    .dst_i    (st_colour),
    .done_o   (blend_done),
    .colour_o (blend_colour)
  );

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == dtab_pkg::ST_EVAL || state_q == dtab_pkg::ST_BLEND ||
                          (start && state_q == dtab_pkg::ST_IDLE)))
    else $error("result without an item in flight");

  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == dtab_pkg::STATUS_CLIPPED) |->
      (res_o.out_red == 8'd0 && res_o.out_green == 8'd0 && res_o.out_blue == 8'd0 &&
       res_o.out_alpha == 8'd0 && res_o.out_depth == 24'sd0))
    else $error("clipped result carries data");

  a_blend_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blend_done |-> state_q == dtab_pkg::ST_BLEND)
    else $error("blend finished outside blend wait");

  a_no_access_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dtab_pkg::ST_CLEAR |-> !mem_ctl.en)
    else $error("store access during clearing sweep");

endmodule
